// ===== src/barycentric_point_in_triangle_defines.svh =====
// Assertion macros shared by the barycentric point-in-triangle RTL.
`ifndef BARYCENTRIC_POINT_IN_TRIANGLE_DEFINES_SVH
`define BARYCENTRIC_POINT_IN_TRIANGLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpt_pkg.sv =====
// Types and constants shared by the barycentric point-in-triangle block.
package bpt_pkg;

  localparam int COORD_BITS = 24;
  localparam int Q_BITS     = 32;
  localparam int TOL_W      = 31;
  localparam int DIV_STAGES = Q_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
  } in_t;

  typedef struct packed {
    logic signed [Q_BITS-1:0] weight_a;
    logic signed [Q_BITS-1:0] weight_b;
    logic signed [Q_BITS-1:0] weight_c;
    logic                     inside_res;
    logic                     degenerate;
  } out_t;

endpackage

// ===== src/bpt_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, with overflow check.
module bpt_div #(
  parameter int NW    = 51,
  parameter int RW    = 84,
  parameter int TAG_W = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [RW-1:0]                num,
  input  logic [NW-1:0]                den,
  input  logic [TAG_W-1:0]             in_tag,
  output logic                         out_vld,
  output logic [bpt_pkg::Q_BITS-1:0]   quo,
  output logic                         ovf,
  output logic [TAG_W-1:0]             out_tag
);
  import bpt_pkg::*;

  localparam int S = DIV_STAGES;

  logic [RW-1:0]     rem_r [S];
  logic [NW-1:0]     den_r [S];
  logic [Q_BITS-1:0] quo_r [S];
  logic              ovf_r [S];
  logic              vld_r [S];
  logic [TAG_W-1:0]  tag_r [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [RW-1:0]     rem_in, rem_nxt, dsh;
    logic [NW-1:0]     den_in;
    logic [Q_BITS-1:0] quo_in, quo_nxt;
    logic              ovf_in, ovf_nxt, vld_in;
    logic [TAG_W-1:0]  tag_in;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign ovf_in = 1'b0;
      assign vld_in = in_vld;
      assign tag_in = in_tag;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign ovf_in = ovf_r[s-1];
      assign vld_in = vld_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    // The first stage checks for a quotient of 2^Q_BITS or more; the rest
    // each settle one quotient bit, most significant first.
    localparam int K = (s == 0) ? Q_BITS : Q_BITS - s;

    assign dsh = RW'(den_in) << K;

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      ovf_nxt = ovf_in;
      if (s == 0) begin
        ovf_nxt = (rem_in >= dsh);
      end else if (rem_in >= dsh) begin
        rem_nxt = rem_in - dsh;
        quo_nxt = quo_in | (Q_BITS'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_in;
      quo_r[s] <= quo_nxt;
      ovf_r[s] <= ovf_nxt;
      tag_r[s] <= tag_in;
    end
  end

  assign out_vld = vld_r[S-1];
  assign quo     = quo_r[S-1];
  assign ovf     = ovf_r[S-1];
  assign out_tag = tag_r[S-1];

endmodule

// ===== src/barycentric_point_in_triangle.sv =====
// Barycentric weights and inside test of a point against a triangle: the top level.
// One triangle/point transaction is accepted every cycle (busy stays low) and its
// result appears on out_data with out_strobe, in order, after passing through four
// front stages (coordinate differences, six products, determinant and numerator
// sums, sign and magnitude), two parallel dividers of 33 stages each (an overflow
// check, then one quotient bit per stage), and one output stage for saturation,
// the third weight, the tolerance compare and the degenerate-case zeroing. The
// tolerance register may be written at any time (cfg_ready is always high) and
// takes effect for results that leave the output stage afterwards; write it only
// while no transaction is in flight.
module barycentric_point_in_triangle #(
  parameter int WEIGHT_FRAC_BITS = 30
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bpt_pkg::in_t                   in_data,
  output logic                           out_strobe,
  output bpt_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpt_pkg::TOL_W-1:0]      cfg_data
);
  import bpt_pkg::*;
  `include "barycentric_point_in_triangle_defines.svh"

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int NW  = (SW > 64) ? 64 : SW;
  localparam int RW  = NW + Q_BITS + 1;
  localparam int EW  = Q_BITS + 2;
  localparam int LAT = 4 + DIV_STAGES + 1;
  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(
    ((64'd1 << WEIGHT_FRAC_BITS) * 64'd5 + 64'd50000) / 64'd100000);
  localparam logic signed [Q_BITS-1:0] W_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
  localparam logic signed [Q_BITS-1:0] W_MIN = {1'b1, {(Q_BITS-1){1'b0}}};
  localparam logic signed [EW-1:0] ONE = EW'(1) << WEIGHT_FRAC_BITS;

  logic [TOL_W-1:0] tol_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  // Stage 1: coordinate differences.
  logic                 v1_r;
  logic signed [DW-1:0] d_bc_y_r, d_cb_x_r, d_ca_y_r, d_ac_x_r, d_ac_y_r, qx_r, qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    d_bc_y_r <= DW'(in_data.by) - DW'(in_data.cy);
    d_cb_x_r <= DW'(in_data.cx) - DW'(in_data.bx);
    d_ca_y_r <= DW'(in_data.cy) - DW'(in_data.ay);
    d_ac_x_r <= DW'(in_data.ax) - DW'(in_data.cx);
    d_ac_y_r <= DW'(in_data.ay) - DW'(in_data.cy);
    qx_r     <= DW'(in_data.px) - DW'(in_data.cx);
    qy_r     <= DW'(in_data.py) - DW'(in_data.cy);
  end

  // Stage 2: products.
  logic                 v2_r;
  logic signed [PW-1:0] p_d0_r, p_d1_r, p_n00_r, p_n01_r, p_n10_r, p_n11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    p_d0_r  <= PW'(d_bc_y_r) * PW'(d_ac_x_r);
    p_d1_r  <= PW'(d_cb_x_r) * PW'(d_ac_y_r);
    p_n00_r <= PW'(d_bc_y_r) * PW'(qx_r);
    p_n01_r <= PW'(d_cb_x_r) * PW'(qy_r);
    p_n10_r <= PW'(d_ca_y_r) * PW'(qx_r);
    p_n11_r <= PW'(d_ac_x_r) * PW'(qy_r);
  end

  // Stage 3: sums, NW bits wide; NW is capped (and the sums wrapped) at 64 bits for the widest coordinates.
  logic                 v3_r;
  logic signed [NW-1:0] det_r, n0_r, n1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    det_r <= NW'(SW'(p_d0_r) + SW'(p_d1_r));
    n0_r  <= NW'(SW'(p_n00_r) + SW'(p_n01_r));
    n1_r  <= NW'(SW'(p_n10_r) + SW'(p_n11_r));
  end

  // Stage 4: signs and magnitudes.
  logic          v4_r, neg0_r, neg1_r, degen_r;
  logic [NW-1:0] md_r, mn0_r, mn1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    md_r    <= det_r[NW-1] ? NW'(-det_r) : NW'(det_r);
    mn0_r   <= n0_r[NW-1] ? NW'(-n0_r) : NW'(n0_r);
    mn1_r   <= n1_r[NW-1] ? NW'(-n1_r) : NW'(n1_r);
    neg0_r  <= n0_r[NW-1] ^ det_r[NW-1];
    neg1_r  <= n1_r[NW-1] ^ det_r[NW-1];
    degen_r <= (det_r == '0);
  end

  logic [RW-1:0]     x0, x1;
  logic              dv0, dv1, ovf0, ovf1;
  logic [Q_BITS-1:0] q0, q1;
  logic [1:0]        tag0;
  logic              tag1;

  assign x0 = RW'(mn0_r) << WEIGHT_FRAC_BITS;
  assign x1 = RW'(mn1_r) << WEIGHT_FRAC_BITS;

  bpt_div #(.NW(NW), .RW(RW), .TAG_W(2)) u_div0 (
    .clk, .rst_n,
    .in_vld (v4_r), .num (x0), .den (md_r), .in_tag ({degen_r, neg0_r}),
    .out_vld(dv0), .quo (q0), .ovf (ovf0), .out_tag(tag0)
  );

  bpt_div #(.NW(NW), .RW(RW), .TAG_W(1)) u_div1 (
    .clk, .rst_n,
    .in_vld (v4_r), .num (x1), .den (md_r), .in_tag (neg1_r),
    .out_vld(dv1), .quo (q1), .ovf (ovf1), .out_tag(tag1)
  );

  // Output stage: signed saturation, third weight, tolerance compare, degenerate zeroing.
  logic signed [Q_BITS-1:0] w0, w1, w2;
  logic signed [EW-1:0]     w2_wide, ntol;
  logic                     degen;
  out_t                     res_nxt, res_r;
  logic                     strobe_r;

  always_comb begin
    degen = tag0[1];
    if (ovf0 || q0[Q_BITS-1]) begin
      w0 = tag0[0] ? W_MIN : W_MAX;
    end else begin
      w0 = tag0[0] ? -$signed(q0) : $signed(q0);
    end
    if (ovf1 || q1[Q_BITS-1]) begin
      w1 = tag1 ? W_MIN : W_MAX;
    end else begin
      w1 = tag1 ? -$signed(q1) : $signed(q1);
    end
    w2_wide = ONE - EW'(w0) - EW'(w1);
    if (w2_wide > EW'(W_MAX)) begin
      w2 = W_MAX;
    end else if (w2_wide < EW'(W_MIN)) begin
      w2 = W_MIN;
    end else begin
      w2 = Q_BITS'(w2_wide);
    end
    ntol = -$signed(EW'(tol_r));
    res_nxt.degenerate = degen;
    if (degen) begin
      res_nxt.weight_a   = '0;
      res_nxt.weight_b   = '0;
      res_nxt.weight_c   = '0;
      res_nxt.inside_res = 1'b0;
    end else begin
      res_nxt.weight_a   = w0;
      res_nxt.weight_b   = w1;
      res_nxt.weight_c   = w2;
      res_nxt.inside_res = (EW'(w0) >= ntol) && (EW'(w1) >= ntol) && (EW'(w2) >= ntol);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv0;
    end
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = res_r;

  `BPT_ASSERT_NOW(a_div_lockstep, 1'b1, dv0 == dv1, "divider valid bits disagree")
  `BPT_ASSERT_NOW(a_degen_zero, out_strobe && out_data.degenerate,
    out_data.weight_a == '0 && out_data.weight_b == '0 && out_data.weight_c == '0
    && !out_data.inside_res, "degenerate result carries nonzero weights")
  `BPT_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, tol_r == $past(cfg_data),
    "tolerance write lost")
  `BPT_ASSERT_NOW(a_latency, start && !busy ##LAT 1'b1, out_strobe,
    "accepted transaction produced no result")

endmodule
